// File: rtl/mrbd_pkg.sv
// shared types and constants for the meter reading to bcd display block
package mrbd_pkg;

   // widths
   localparam int ValW    = 32;
   localparam int DivW    = 38;
   localparam int DigW    = 4;
   localparam int NumDig  = 10;
   localparam int BcdW    = DigW * NumDig;
   localparam int OutW    = 32;
   localparam int SignBit = 23;

   // reciprocal of 9 for a 32-bit dividend, quotient = (x * ChbMagic) >> ChbShift
   localparam logic [31:0] ChbMagic = 32'h38E3_8E39;
   localparam int          ChbShift = 33;

   // quantity codes
   localparam logic [2:0] TypeActive   = 3'd0;
   localparam logic [2:0] TypeReactive = 3'd1;
   localparam logic [2:0] TypeVoltage  = 3'd2;
   localparam logic [2:0] TypeCurrent1 = 3'd3;
   localparam logic [2:0] TypeCurrent2 = 3'd4;
   localparam logic [2:0] TypeFreq     = 3'd5;
   localparam logic [2:0] TypeApparent = 3'd6;

   // register indexes
   localparam logic [2:0] CsrPowerGain    = 3'd0;
   localparam logic [2:0] CsrVoltageGain  = 3'd1;
   localparam logic [2:0] CsrCurrent1Gain = 3'd2;
   localparam logic [2:0] CsrCurrent2Gain = 3'd3;
   localparam logic [2:0] CsrApparentGain = 3'd4;
   localparam logic [2:0] CsrFreqNum      = 3'd5;
   localparam logic [2:0] CsrFreqMode     = 3'd6;

   // frequency mode codes
   localparam logic [1:0] FreqModeX16 = 2'd0;
   localparam logic [1:0] FreqModeX64 = 2'd2;

   // operations applied to the quotient
   localparam logic [1:0] PostNone = 2'd0;
   localparam logic [1:0] PostX10  = 2'd1;
   localparam logic [1:0] PostSh4  = 2'd2;
   localparam logic [1:0] PostSh6  = 2'd3;

   // divider cell state
   typedef struct packed {
      logic [ValW-1:0] rem;
      logic [DivW-1:0] work;
      logic [ValW-1:0] divisor;
   } div_type;

   // per-request flags that ride along the divider
   typedef struct packed {
      logic            zero;
      logic            bypass;
      logic [ValW-1:0] bypass_val;
      logic [1:0]      post;
      logic            sign;
   } side_type;

   // binary to bcd cell state
   typedef struct packed {
      logic [BcdW-1:0] bcd;
      logic [ValW-1:0] bin;
      logic            sign;
   } dd_type;

endpackage

// File: rtl/mrbd_div_cell.sv
// one restoring division step: one quotient bit per cell
module mrbd_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  mrbd_pkg::div_type  in_div,
   input  mrbd_pkg::side_type in_side,
   output logic               out_valid,
   output mrbd_pkg::div_type  out_div,
   output mrbd_pkg::side_type out_side
);

   logic                      valid_ff;
   mrbd_pkg::div_type         div_ff, div_in;
   mrbd_pkg::side_type        side_ff;
   logic [mrbd_pkg::ValW:0]   trial;
   logic [mrbd_pkg::ValW:0]   diff;
   logic                      ge;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      trial = {in_div.rem, in_div.work[mrbd_pkg::DivW-1]};
      diff  = trial - {1'b0, in_div.divisor};
      ge    = trial >= {1'b0, in_div.divisor};
      div_in.rem     = ge ? diff[mrbd_pkg::ValW-1:0] : trial[mrbd_pkg::ValW-1:0];
      div_in.work    = {in_div.work[mrbd_pkg::DivW-2:0], ge};
      div_in.divisor = in_div.divisor;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= div_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/mrbd_dd_cell.sv
// one double-dabble step: adjust digits then shift in one binary bit
module mrbd_dd_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  mrbd_pkg::dd_type  in_dd,
   output logic              out_valid,
   output mrbd_pkg::dd_type  out_dd
);

   logic                          valid_ff;
   mrbd_pkg::dd_type              dd_ff, dd_in;
   logic [mrbd_pkg::BcdW-1:0]     adj;

   // add 3 to every digit of 5 or more, then shift
   always_comb begin
      for (int i = 0; i < mrbd_pkg::NumDig; i++) begin
         if (in_dd.bcd[mrbd_pkg::DigW*i +: mrbd_pkg::DigW] >= 4'd5) begin
            adj[mrbd_pkg::DigW*i +: mrbd_pkg::DigW] =
               in_dd.bcd[mrbd_pkg::DigW*i +: mrbd_pkg::DigW] + 4'd3;
         end else begin
            adj[mrbd_pkg::DigW*i +: mrbd_pkg::DigW] =
               in_dd.bcd[mrbd_pkg::DigW*i +: mrbd_pkg::DigW];
         end
      end
      dd_in.bcd  = {adj[mrbd_pkg::BcdW-2:0], in_dd.bin[mrbd_pkg::ValW-1]};
      dd_in.bin  = {in_dd.bin[mrbd_pkg::ValW-2:0], 1'b0};
      dd_in.sign = in_dd.sign;
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         dd_ff <= dd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dd    = dd_ff;

endmodule

// File: rtl/meter_reading_to_bcd_display_top.sv
// top level: scaling front end, divider cell chain, bcd cell chain
//
//  channel | direction | contents
//  req_    | in        | tdata raw_value, tuser type/channel_b/reverse_direction
//  rsp_    | out       | tdata bcd_value
//  csr_    | in        | index, data register write
//
// one request per cycle sustained while the chain is not held; 72 register stages: one input stage,
// 38 divider cells (one quotient bit each), one scaling stage, 32 bcd cells.
// reset clears all stage valids and the registers to zero.
// the whole chain advances together; it holds while a result waits on rsp_tready.
module meter_reading_to_bcd_display_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] raw_value
   input  logic [4:0]  req_tuser,   // [2:0] req_type, [3] channel_b, [4] reverse_direction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] bcd_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int NDiv = mrbd_pkg::DivW;
   localparam int NDd  = mrbd_pkg::ValW;

   logic        en;
   logic [31:0] power_gain_ff, voltage_gain_ff, cur1_gain_ff, cur2_gain_ff;
   logic [31:0] apparent_gain_ff, freq_num_ff;
   logic [1:0]  freq_mode_ff;

   logic        s0_valid_ff;
   logic [2:0]  s0_type_ff;
   logic [31:0] s0_raw_ff;
   logic        s0_chb_ff, s0_rev_ff;
   logic [30:0] s0_chb_gain_ff;
   logic [31:0] g5;
   logic [63:0] chb_prod;

   logic [31:0] mag;
   logic [31:0] app_gain;
   mrbd_pkg::div_type  div0;
   mrbd_pkg::side_type side0;

   logic               div_valid [0:NDiv];
   mrbd_pkg::div_type  div_d     [0:NDiv];
   mrbd_pkg::side_type div_side  [0:NDiv];

   logic        pv_valid_ff;
   logic [31:0] pv_val_ff, pv_val_in;
   logic        pv_sign_ff;
   logic [31:0] quo;

   logic             dd_valid [0:NDd];
   mrbd_pkg::dd_type dd_d     [0:NDd];

   // chain advances unless a result is stalled
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         power_gain_ff    <= '0;
         voltage_gain_ff  <= '0;
         cur1_gain_ff     <= '0;
         cur2_gain_ff     <= '0;
         apparent_gain_ff <= '0;
         freq_num_ff      <= '0;
         freq_mode_ff     <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            mrbd_pkg::CsrPowerGain:    power_gain_ff    <= csr_data;
            mrbd_pkg::CsrVoltageGain:  voltage_gain_ff  <= csr_data;
            mrbd_pkg::CsrCurrent1Gain: cur1_gain_ff     <= csr_data;
            mrbd_pkg::CsrCurrent2Gain: cur2_gain_ff     <= csr_data;
            mrbd_pkg::CsrApparentGain: apparent_gain_ff <= csr_data;
            mrbd_pkg::CsrFreqNum:      freq_num_ff      <= csr_data;
            mrbd_pkg::CsrFreqMode:     freq_mode_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // channel b gain: (5 * gain mod 2^32) / 9 by reciprocal multiply
   assign g5       = {apparent_gain_ff[29:0], 2'b00} + apparent_gain_ff;
   assign chb_prod = 64'(g5) * 64'(mrbd_pkg::ChbMagic);

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_type_ff     <= req_tuser[2:0];
         s0_chb_ff      <= req_tuser[3];
         s0_rev_ff      <= req_tuser[4];
         s0_raw_ff      <= req_tdata;
         s0_chb_gain_ff <= chb_prod[mrbd_pkg::ChbShift +: 31];
      end
   end

   // dividend, divisor and flags per quantity
   assign mag      = s0_raw_ff[31] ? (~s0_raw_ff + 32'd1) : s0_raw_ff;
   assign app_gain = s0_chb_ff ? {1'b0, s0_chb_gain_ff} : apparent_gain_ff;

   always_comb begin
      div0.rem         = '0;
      div0.work        = '0;
      div0.divisor     = 32'd1;
      side0.zero       = 1'b1;
      side0.bypass     = 1'b0;
      side0.bypass_val = mag;
      side0.post       = mrbd_pkg::PostNone;
      side0.sign       = 1'b0;
      case (s0_type_ff)
         mrbd_pkg::TypeActive, mrbd_pkg::TypeReactive: begin
            div0.work    = NDiv'(mag) * NDiv'(100);
            div0.divisor = power_gain_ff;
            side0.zero   = 1'b0;
            side0.bypass = power_gain_ff == '0;
            side0.sign   = s0_rev_ff;
         end
         mrbd_pkg::TypeApparent: begin
            div0.work    = NDiv'(mag) * NDiv'(10);
            div0.divisor = app_gain;
            side0.zero   = 1'b0;
            side0.bypass = app_gain == '0;
            side0.sign   = s0_rev_ff;
         end
         mrbd_pkg::TypeVoltage: begin
            div0.work    = NDiv'(s0_raw_ff);
            div0.divisor = voltage_gain_ff;
            side0.zero   = voltage_gain_ff == '0;
            side0.post   = mrbd_pkg::PostX10;
         end
         mrbd_pkg::TypeCurrent1: begin
            div0.work    = NDiv'(32'(s0_raw_ff * 32'd10));
            div0.divisor = cur1_gain_ff;
            side0.zero   = cur1_gain_ff == '0;
            side0.sign   = s0_rev_ff && (cur1_gain_ff != '0);
         end
         mrbd_pkg::TypeCurrent2: begin
            div0.work    = NDiv'(32'(s0_raw_ff * 32'd10));
            div0.divisor = cur2_gain_ff;
            side0.zero   = cur2_gain_ff == '0;
            side0.sign   = s0_rev_ff && (cur2_gain_ff != '0);
         end
         mrbd_pkg::TypeFreq: begin
            div0.work    = NDiv'(32'(freq_num_ff * 32'd100));
            div0.divisor = s0_raw_ff;
            side0.zero   = s0_raw_ff == '0;
            if (freq_mode_ff == mrbd_pkg::FreqModeX16) begin
               side0.post = mrbd_pkg::PostSh4;
            end else if (freq_mode_ff == mrbd_pkg::FreqModeX64) begin
               side0.post = mrbd_pkg::PostSh6;
            end else begin
               side0.post = mrbd_pkg::PostNone;
            end
         end
         default: begin
            side0.zero = 1'b1;
         end
      endcase
   end

   assign div_valid[0] = s0_valid_ff;
   assign div_d[0]     = div0;
   assign div_side[0]  = side0;

   // divider cell chain
   for (genvar i = 0; i < NDiv; i++) begin : g_div
      mrbd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_valid[i]),
         .in_div    (div_d[i]),
         .in_side   (div_side[i]),
         .out_valid (div_valid[i+1]),
         .out_div   (div_d[i+1]),
         .out_side  (div_side[i+1])
      );
   end

   // quotient scaling and special cases
   assign quo = div_d[NDiv].work[31:0];

   always_comb begin
      if (div_side[NDiv].zero) begin
         pv_val_in = '0;
      end else if (div_side[NDiv].bypass) begin
         pv_val_in = div_side[NDiv].bypass_val;
      end else begin
         case (div_side[NDiv].post)
            mrbd_pkg::PostX10: pv_val_in = {quo[28:0], 3'b000} + {quo[30:0], 1'b0};
            mrbd_pkg::PostSh4: pv_val_in = {quo[27:0], 4'b0000};
            mrbd_pkg::PostSh6: pv_val_in = {quo[25:0], 6'b000000};
            default:           pv_val_in = quo;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_valid_ff <= 1'b0;
      end else if (en) begin
         pv_valid_ff <= div_valid[NDiv];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pv_val_ff  <= pv_val_in;
         pv_sign_ff <= div_side[NDiv].sign;
      end
   end

   assign dd_valid[0]   = pv_valid_ff;
   assign dd_d[0].bcd   = '0;
   assign dd_d[0].bin   = pv_val_ff;
   assign dd_d[0].sign  = pv_sign_ff;

   // binary to bcd cell chain
   for (genvar j = 0; j < NDd; j++) begin : g_dd
      mrbd_dd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dd_valid[j]),
         .in_dd     (dd_d[j]),
         .out_valid (dd_valid[j+1]),
         .out_dd    (dd_d[j+1])
      );
   end

   // low eight digits are the value mod 1e8, sign mark ORed into bit 23
   assign rsp_tvalid = dd_valid[NDd];
   assign rsp_tdata  = dd_d[NDd].bcd[mrbd_pkg::OutW-1:0]
                       | {8'd0, dd_d[NDd].sign, 23'd0};

endmodule

// File: tb/tb.sv
// testbench for the meter reading to bcd display block: table and random requests
`timescale 1ns / 100ps

module tb;

   localparam int Latency   = 73;
   localparam int WatchMax  = 4000;
   localparam logic [2:0] TypeNone = 3'd7;
   localparam logic [2:0] CsrBad   = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [4:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // local copy of the gain registers
   logic [31:0] gain_q [0:6];

   logic [31:0] bcd_expect_q [$];
   int          fail_count = 0;
   int          stall_quiet = 0;
   int          idle_watch = 0;
   bit          done_stim = 1'b0;
   bit          quiet_tail = 1'b0;

   meter_reading_to_bcd_display_top uut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] bcd_of(logic [31:0] v);
      logic [31:0] r;
      r = '0;
      v = v % 32'd100000000;
      for (int d = 0; d < 8; d++) begin
         r[4*d +: 4] = 4'(v % 10);
         v = v / 10;
      end
      return r;
   endfunction

   function automatic logic [31:0] abs_of(logic [31:0] raw);
      return raw[31] ? (~raw + 32'd1) : raw;
   endfunction

   // predicted display word for one reading
   function automatic logic [31:0] display_word(logic [2:0] kind, logic [31:0] raw,
                                                logic chb, logic rev);
      logic [31:0] g, v, res;
      logic [63:0] wide;
      res = '0;
      case (kind)
         mrbd_pkg::TypeActive, mrbd_pkg::TypeReactive: begin
            g = gain_q[mrbd_pkg::CsrPowerGain];
            wide = 64'(abs_of(raw)) * 64'd100;
            v = (g == 0) ? abs_of(raw) : 32'(wide / 64'(g));
            res = bcd_of(v) | (rev ? 32'h800000 : 32'h0);
         end
         mrbd_pkg::TypeApparent: begin
            g = gain_q[mrbd_pkg::CsrApparentGain];
            if (chb) g = 32'(g * 32'd5) / 32'd9;
            wide = 64'(abs_of(raw)) * 64'd10;
            v = (g == 0) ? abs_of(raw) : 32'(wide / 64'(g));
            res = bcd_of(v) | (rev ? 32'h800000 : 32'h0);
         end
         mrbd_pkg::TypeVoltage: begin
            g = gain_q[mrbd_pkg::CsrVoltageGain];
            if (g != 0) res = bcd_of(32'((raw / g) * 32'd10));
         end
         mrbd_pkg::TypeCurrent1, mrbd_pkg::TypeCurrent2: begin
            g = (kind == mrbd_pkg::TypeCurrent1) ? gain_q[mrbd_pkg::CsrCurrent1Gain]
                                                 : gain_q[mrbd_pkg::CsrCurrent2Gain];
            if (g != 0) res = bcd_of(32'(raw * 32'd10) / g) | (rev ? 32'h800000 : 32'h0);
         end
         mrbd_pkg::TypeFreq: begin
            if (raw != 0) begin
               v = 32'(gain_q[mrbd_pkg::CsrFreqNum] * 32'd100) / raw;
               if (gain_q[mrbd_pkg::CsrFreqMode][1:0] == mrbd_pkg::FreqModeX16)
                  v = v * 32'd16;
               else if (gain_q[mrbd_pkg::CsrFreqMode][1:0] == mrbd_pkg::FreqModeX64)
                  v = v * 32'd64;
               res = bcd_of(v);
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // one request, with random gaps unless in the quiet tail
   task automatic send_reading(logic [2:0] kind, logic [31:0] raw, logic chb, logic rev,
                               bit quiet, bit has_want, logic [31:0] want);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      req_tuser  <= {rev, chb, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bcd_expect_q.push_back(has_want ? want : display_word(kind, raw, chb, rev));
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx <= mrbd_pkg::CsrFreqMode)
         gain_q[idx] = (idx == mrbd_pkg::CsrFreqMode) ? {30'd0, val[1:0]} : val;
      @(posedge clock);
   endtask

   task automatic drain_pipe;
      req_tvalid <= 1'b0;
      while (bcd_expect_q.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // directed table
   typedef struct {
      logic [2:0]  kind;
      logic [31:0] raw;
      logic        chb;
      logic        rev;
      bit          has_want;
      logic [31:0] want;
   } row_type;

   row_type table_rows [0:11] = '{
      '{mrbd_pkg::TypeActive,   32'd0,        1'b0, 1'b0, 1'b1, 32'h0},
      '{mrbd_pkg::TypeActive,   32'd12345678, 1'b0, 1'b1, 1'b1, 32'h12B45678},
      '{mrbd_pkg::TypeReactive, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b1, 32'h1},
      '{mrbd_pkg::TypeReactive, 32'h80000000, 1'b1, 1'b1, 1'b0, 32'h0},
      '{mrbd_pkg::TypeApparent, 32'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0},
      '{mrbd_pkg::TypeApparent, 32'd99,       1'b1, 1'b1, 1'b1, 32'h00800099},
      '{mrbd_pkg::TypeVoltage,  32'hFFFFFFFF, 1'b0, 1'b1, 1'b1, 32'h0},
      '{mrbd_pkg::TypeCurrent1, 32'd5,        1'b0, 1'b1, 1'b1, 32'h0},
      '{mrbd_pkg::TypeCurrent2, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1, 32'h0},
      '{mrbd_pkg::TypeFreq,     32'd0,        1'b0, 1'b0, 1'b1, 32'h0},
      '{mrbd_pkg::TypeFreq,     32'd1,        1'b0, 1'b0, 1'b1, 32'h0},
      '{TypeNone,               32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 32'h0}
   };

   // typed results hold only for the reset register values
   task automatic run_table(bit quiet, bit use_want);
      foreach (table_rows[i])
         send_reading(table_rows[i].kind, table_rows[i].raw, table_rows[i].chb,
                      table_rows[i].rev, quiet, use_want && table_rows[i].has_want,
                      table_rows[i].want);
   endtask

   function automatic logic [31:0] rand_raw();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 3));
         1: return 32'hFFFFFFFF - 32'($urandom_range(0, 3));
         2: return 32'($urandom_range(0, 100000));
         3: return 32'h80000000 ^ 32'($urandom_range(0, 1));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFFFFFF;
         2: return 32'($urandom_range(1, 20));
         3: return 32'($urandom_range(1, 100000));
         default: return $urandom();
      endcase
   endfunction

   task automatic random_phase(int count, bit quiet);
      for (int k = 0; k < count; k++)
         send_reading(3'($urandom_range(0, 7)), rand_raw(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), quiet, 1'b0, 32'h0);
   endtask

   // stimulus sequence
   initial begin
      for (int i = 0; i < 7; i++) gain_q[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_table(1'b0, 1'b1);
      drain_pipe();
      // every register at extremes, plus an ignored index
      write_reg(mrbd_pkg::CsrPowerGain, 32'hFFFFFFFF);
      write_reg(mrbd_pkg::CsrVoltageGain, 32'hFFFFFFFF);
      write_reg(mrbd_pkg::CsrCurrent1Gain, 32'd1);
      write_reg(mrbd_pkg::CsrCurrent2Gain, 32'hFFFFFFFF);
      write_reg(mrbd_pkg::CsrApparentGain, 32'hFFFFFFFF);
      write_reg(mrbd_pkg::CsrFreqNum, 32'hFFFFFFFF);
      write_reg(mrbd_pkg::CsrFreqMode, 32'hFFFFFFFF);
      write_reg(CsrBad, 32'h12345678);
      run_table(1'b0, 1'b0);
      random_phase(100, 1'b0);
      drain_pipe();
      for (int ph = 0; ph < 9; ph++) begin
         for (int r = 0; r <= 5; r++) write_reg(3'(r), rand_gain());
         write_reg(mrbd_pkg::CsrFreqMode, 32'(ph % 4));
         if (ph >= 7) quiet_tail = 1'b1;
         random_phase(115, ph >= 7);
         drain_pipe();
      end
      done_stim = 1'b1;
   end

   // result side: random stalls, none in the tail
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_quiet <= 0;
      end else if (quiet_tail || done_stim) begin
         rsp_tready  <= 1'b1;
         stall_quiet <= 0;
      end else if (stall_quiet < 0) begin
         rsp_tready  <= 1'b0;
         stall_quiet <= stall_quiet + 1;
      end else if (stall_quiet > 0 || $urandom_range(0, 5) != 0) begin
         rsp_tready <= 1'b1;
         if (stall_quiet > 0) stall_quiet <= stall_quiet - 1;
         else if ($urandom_range(0, 40) == 0) stall_quiet <= 40;
      end else begin
         rsp_tready  <= 1'b0;
         stall_quiet <= -int'($urandom_range(0, 16));
      end
   end

   // compare results, watchdog and end of run
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         idle_watch <= 0;
         if (bcd_expect_q.size() == 0) begin
            report_mismatch("unexpected bcd_value", rsp_tdata, 32'h0);
         end else begin
            if (rsp_tdata !== bcd_expect_q[0])
               report_mismatch("bcd_value", rsp_tdata, bcd_expect_q[0]);
            void'(bcd_expect_q.pop_front());
         end
      end else if (!reset && ((req_tvalid && req_tready) || (csr_valid && csr_ready))) begin
         idle_watch <= 0;
      end else if (!reset) begin
         idle_watch <= idle_watch + 1;
      end
      if (idle_watch > WatchMax) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (done_stim) begin
         if (fail_count == 0 && bcd_expect_q.size() == 0) $display("SCOREBOARD CLEAN");
         else $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
